// ----- hw/rtl/sqs_pkg.sv -----
package sqs_pkg;

  localparam int COORD_W   = 32;
  localparam int SLOT_W    = 6;
  localparam int INDEX_W   = 16;
  localparam int CORNER_W  = 2;
  localparam int QUAD_INDICES = 6;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = 1;
  localparam int QUEUE_CNT_W  = 2;

  typedef struct packed {
    logic [31:0]        texture_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_w;
    logic signed [31:0] size_h;
    logic [31:0]        rgba;
    logic [31:0]        uv_corner0;
    logic [31:0]        uv_corner1;
    logic [31:0]        uv_corner2;
    logic [31:0]        uv_corner3;
  } sprite_t;

  typedef struct packed {
    logic signed [31:0]   vert_x;
    logic signed [31:0]   vert_y;
    logic signed [31:0]   vert_z;
    logic [31:0]          vert_uv;
    logic [SLOT_W-1:0]    slot;
    logic [31:0]          vert_color;
    logic                 flush_before;
    logic [INDEX_W-1:0]   flushed_indices;
    logic [CORNER_W-1:0]  corner;
    logic                 last;
  } vertex_t;

  typedef struct packed {
    sprite_t             sprite;
    logic [SLOT_W-1:0]   slot;
    logic                flush;
    logic [INDEX_W-1:0]  flushed;
  } quad_req_t;

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/sprite_quad_setup_with_texture_slots.sv -----
// Each sprite yields four vertices, one per cycle from the output register unless stalled.
// An untextured sprite skips the texture lookup; a textured one scans the slot RAM up to a hit,
// or through every slot in use on a miss, then takes a new slot, flushing a full table first.
// The lookup reads one slot RAM entry a cycle. The back end emits the queue head's vertices
// while the front end looks up the next sprite, the two overlapped through a 2-entry queue.
// Synchronous reset empties the slot table, index count, queue and output; slot RAM is not swept.
module sprite_quad_setup_with_texture_slots #(
  parameter int SLOT_COUNT = 32,
  parameter int MAX_QUADS  = 8192
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sprite_valid,
  output logic             sprite_ready,
  input  sqs_pkg::sprite_t sprite,
  output logic             vertex_valid,
  input  logic             vertex_ready,
  output sqs_pkg::vertex_t vertex
);
  import sqs_pkg::*;

  logic      push_valid;
  logic      push_ready;
  quad_req_t push_data;
  logic      head_valid;
  logic      pop;
  quad_req_t head;

  sqs_front #(.SLOT_COUNT(SLOT_COUNT), .MAX_QUADS(MAX_QUADS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .sprite_valid (sprite_valid),
    .sprite_ready (sprite_ready),
    .sprite       (sprite),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  sqs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  sqs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex)
  );

endmodule

// ----- hw/rtl/sqs_ram.sv -----
module sqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sqs_front.sv -----
module sqs_front #(
  parameter int SLOT_COUNT = 32,
  parameter int MAX_QUADS  = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sprite_valid,
  output logic               sprite_ready,
  input  sqs_pkg::sprite_t   sprite,
  output logic               push_valid,
  input  logic               push_ready,
  output sqs_pkg::quad_req_t push_data
);
  import sqs_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam logic [INDEX_W-1:0] INDEX_CAP = INDEX_W'(MAX_QUADS * QUAD_INDICES);
  localparam logic [UW-1:0] FULL_COUNT = UW'(SLOT_COUNT);

  typedef enum logic [1:0] {IDLE, SCAN, MISS, PUSH} state_t;

  state_t             state;
  sprite_t            item;
  logic [IW-1:0]      chk;
  logic [UW-1:0]      slots_used;
  logic [INDEX_W-1:0] pending;
  logic [SLOT_W-1:0]  slot;
  logic               flush;
  logic [INDEX_W-1:0] flushed;

  logic [IW:0]        chk_inc;
  logic [UW-1:0]      used_inc;
  logic [31:0]        rdata;
  logic [IW-1:0]      raddr;
  logic               we;
  logic [IW-1:0]      waddr;
  logic               table_full;

  function automatic logic [INDEX_W-1:0] add_quad(input logic [INDEX_W-1:0] base);
    logic [INDEX_W:0] s;
    s = {1'b0, base} + (INDEX_W+1)'(QUAD_INDICES);
    if (s > {1'b0, INDEX_CAP}) begin
      return INDEX_CAP;
    end
    return s[INDEX_W-1:0];
  endfunction

  assign chk_inc    = {1'b0, chk} + (IW+1)'(1);
  assign used_inc   = slots_used + UW'(1);
  assign table_full = (slots_used == FULL_COUNT);
  assign raddr      = (state == SCAN) ? chk_inc[IW-1:0] : '0;
  assign we         = (state == MISS);
  assign waddr      = table_full ? '0 : slots_used[IW-1:0];

  sqs_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.texture_id),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sprite_ready      = (state == IDLE);
  assign push_valid        = (state == PUSH);
  assign push_data.sprite  = item;
  assign push_data.slot    = slot;
  assign push_data.flush   = flush;
  assign push_data.flushed = flushed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      slots_used <= '0;
      pending    <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (sprite_valid) begin
            item    <= sprite;
            chk     <= '0;
            flush   <= 1'b0;
            flushed <= '0;
            if (sprite.texture_id == '0) begin
              slot    <= '0;
              pending <= add_quad(pending);
              state   <= PUSH;
            end else if (slots_used == '0) begin
              state <= MISS;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (rdata == item.texture_id) begin
            slot    <= SLOT_W'(chk_inc);
            pending <= add_quad(pending);
            state   <= PUSH;
          end else if (UW'(chk_inc) == slots_used) begin
            state <= MISS;
          end else begin
            chk <= chk_inc[IW-1:0];
          end
        end
        MISS: begin
          if (table_full) begin
            flush      <= 1'b1;
            flushed    <= pending;
            pending    <= add_quad('0);
            slots_used <= UW'(1);
            slot       <= SLOT_W'(1);
          end else begin
            pending    <= add_quad(pending);
            slots_used <= used_inc;
            slot       <= SLOT_W'(used_inc);
          end
          state <= PUSH;
        end
        PUSH: begin
          if (push_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sqs_queue.sv -----
module sqs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  sqs_pkg::quad_req_t push_data,
  output logic               head_valid,
  input  logic               pop,
  output sqs_pkg::quad_req_t head
);
  import sqs_pkg::*;

  quad_req_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr;
  logic [QUEUE_PTR_W-1:0] rptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/sqs_back.sv -----
module sqs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  sqs_pkg::quad_req_t head,
  output logic               pop,
  output logic               vertex_valid,
  input  logic               vertex_ready,
  output sqs_pkg::vertex_t   vertex
);
  import sqs_pkg::*;

  logic [CORNER_W-1:0] cnt;
  logic                load;
  logic [COORD_W-1:0]  xw;
  logic [COORD_W-1:0]  yh;
  vertex_t             vert_next;

  assign load = (!vertex_valid || vertex_ready) && head_valid;
  assign pop  = load && (cnt == CORNER_W'(3));
  assign xw   = sat_add(head.sprite.pos_x, head.sprite.size_w);
  assign yh   = sat_add(head.sprite.pos_y, head.sprite.size_h);

  always_comb begin
    vert_next.vert_x = head.sprite.pos_x;
    vert_next.vert_y = head.sprite.pos_y;
    vert_next.vert_uv = head.sprite.uv_corner0;
    case (cnt)
      2'd1: begin
        vert_next.vert_y  = yh;
        vert_next.vert_uv = head.sprite.uv_corner1;
      end
      2'd2: begin
        vert_next.vert_x  = xw;
        vert_next.vert_y  = yh;
        vert_next.vert_uv = head.sprite.uv_corner2;
      end
      2'd3: begin
        vert_next.vert_x  = xw;
        vert_next.vert_uv = head.sprite.uv_corner3;
      end
      default: begin
      end
    endcase
    vert_next.vert_z          = head.sprite.pos_z;
    vert_next.slot            = head.slot;
    vert_next.vert_color      = (head.sprite.texture_id == '0) ? head.sprite.rgba : '0;
    vert_next.flush_before    = (cnt == '0) && head.flush;
    vert_next.flushed_indices = (cnt == '0) ? head.flushed : '0;
    vert_next.corner          = cnt;
    vert_next.last            = (cnt == CORNER_W'(3));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vertex <= vert_next;
    end
    if (rst) begin
      vertex_valid <= 1'b0;
      cnt          <= '0;
    end else if (load) begin
      vertex_valid <= 1'b1;
      cnt          <= cnt + CORNER_W'(1);
    end else if (vertex_ready) begin
      vertex_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/sqs_checker.sv -----
module sqs_checker (
  input logic             clk,
  input logic             rst,
  input logic             vertex_valid,
  input logic             vertex_ready,
  input sqs_pkg::vertex_t vertex
);
  import sqs_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst && $past(rst) |-> !vertex_valid)
    else $error("vertex valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && !vertex_ready |=> vertex_valid && $stable(vertex))
    else $error("stalled vertex changed");

  a_corner_seq: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && vertex_ready && !vertex.last |=>
      !vertex_valid || (vertex.corner == CORNER_W'($past(vertex.corner) + 2'd1)))
    else $error("corner sequence broken");

  a_flush_first: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && vertex.flush_before |->
      (vertex.corner == '0) && (vertex.slot == SLOT_W'(1)) && (vertex.vert_color == '0))
    else $error("flush on wrong vertex");

endmodule

bind sprite_quad_setup_with_texture_slots sqs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex_valid (vertex_valid),
  .vertex_ready (vertex_ready),
  .vertex       (vertex)
);

// ----- sim/sprite_quad_setup_with_texture_slots_tb.sv -----
`timescale 1ns / 100ps

module sprite_quad_setup_with_texture_slots_tb;
  import sqs_pkg::*;

  localparam int SLOT_COUNT = 32;
  localparam int MAX_QUADS = 8192;
  localparam int INDEX_CAP = MAX_QUADS * QUAD_INDICES;
  localparam int RANDOM_ITEMS = 375;
  localparam int QUIET_ITEMS = 60;
  localparam int ID_POOL = 40;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  typedef struct {
    sprite_t s;
    bit      typed;
    vertex_t v0;
  } row_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    sprite_valid = 1'b0;
  logic    sprite_ready;
  sprite_t sprite = '0;
  logic    vertex_valid;
  logic    vertex_ready = 1'b0;
  vertex_t vertex;

  vertex_t     pending_verts[$];
  logic [31:0] tex_ids[SLOT_COUNT];
  int          tex_used = 0;
  int          index_count = 0;
  int          mismatch_count = 0;
  bit          quiet = 1'b0;

  sprite_quad_setup_with_texture_slots #(
    .SLOT_COUNT(SLOT_COUNT),
    .MAX_QUADS (MAX_QUADS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .sprite_valid(sprite_valid),
    .sprite_ready(sprite_ready),
    .sprite      (sprite),
    .vertex_valid(vertex_valid),
    .vertex_ready(vertex_ready),
    .vertex      (vertex)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] clamp_sum(input logic [31:0] a, input logic [31:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > COORD_MAX) return 32'h7FFF_FFFF;
    if (s < COORD_MIN) return 32'h8000_0000;
    return s[31:0];
  endfunction

  // Updates the slot table, queues the four corners, then updates the index count.
  task automatic predict_quad(input sprite_t s);
    logic [SLOT_W-1:0]  slot_no;
    logic [31:0]        color;
    logic               flush;
    logic [INDEX_W-1:0] flushed;
    logic [31:0]        xw, yh;
    logic [31:0]        xs[4], ys[4], uvs[4];
    vertex_t            v;
    int                 hit;
    slot_no = '0;
    color = '0;
    flush = 1'b0;
    flushed = '0;
    hit = -1;
    if (s.texture_id != 0) begin
      for (int i = 0; i < tex_used; i++) begin
        if (hit < 0 && tex_ids[i] == s.texture_id) hit = i;
      end
      if (hit >= 0) begin
        slot_no = SLOT_W'(hit + 1);
      end else begin
        if (tex_used >= SLOT_COUNT) begin
          flush = 1'b1;
          flushed = INDEX_W'(index_count);
          index_count = 0;
          tex_used = 0;
        end
        tex_ids[tex_used] = s.texture_id;
        tex_used++;
        slot_no = SLOT_W'(tex_used);
      end
    end else begin
      color = s.rgba;
    end
    xw = clamp_sum(s.pos_x, s.size_w);
    yh = clamp_sum(s.pos_y, s.size_h);
    xs = '{s.pos_x, s.pos_x, xw, xw};
    ys = '{s.pos_y, yh, yh, s.pos_y};
    uvs = '{s.uv_corner0, s.uv_corner1, s.uv_corner2, s.uv_corner3};
    for (int k = 0; k < 4; k++) begin
      v.vert_x = xs[k];
      v.vert_y = ys[k];
      v.vert_z = s.pos_z;
      v.vert_uv = uvs[k];
      v.slot = slot_no;
      v.vert_color = color;
      v.flush_before = (k == 0) ? flush : 1'b0;
      v.flushed_indices = (k == 0) ? flushed : '0;
      v.corner = CORNER_W'(k);
      v.last = (k == 3);
      pending_verts.insert(pending_verts.size(), v);
    end
    index_count = (index_count + QUAD_INDICES > INDEX_CAP) ? INDEX_CAP
                                                           : index_count + QUAD_INDICES;
  endtask

  task automatic send_sprite(input sprite_t s);
    sprite <= s;
    sprite_valid <= 1'b1;
    do @(posedge clk); while (!sprite_ready);
    predict_quad(s);
  endtask

  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sprite_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  function automatic sprite_t make_sprite(input logic [31:0] id, x, y, z, w, h, rgba,
                                          uv0, uv1, uv2, uv3);
    sprite_t s;
    s = '{id, x, y, z, w, h, rgba, uv0, uv1, uv2, uv3};
    return s;
  endfunction

  function automatic vertex_t first_corner(input logic [31:0] x, y, z, uv,
                                           input logic [SLOT_W-1:0] slot_no,
                                           input logic [31:0] color);
    vertex_t v;
    v = '{x, y, z, uv, slot_no, color, 1'b0, '0, '0, 1'b0};
    return v;
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [19:0] r;
    r = 20'($urandom);
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_0000 | 32'($urandom_range(0, 16'hFFFF));
      3, 4, 5: return {{12{r[19]}}, r};
      default: return $urandom;
    endcase
  endfunction

  function automatic sprite_t rand_sprite(input logic [31:0] id);
    return make_sprite(id, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic report_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && vertex_valid && vertex_ready) begin
      if (pending_verts.size() == 0) begin
        $display("%0t: unexpected vertex, expected none, actual %h", $time, vertex);
        mismatch_count++;
      end else begin
        e = pending_verts.pop_front();
        report_field("vert_x", e.vert_x, vertex.vert_x);
        report_field("vert_y", e.vert_y, vertex.vert_y);
        report_field("vert_z", e.vert_z, vertex.vert_z);
        report_field("vert_uv", e.vert_uv, vertex.vert_uv);
        report_field("slot", 32'(e.slot), 32'(vertex.slot));
        report_field("vert_color", e.vert_color, vertex.vert_color);
        report_field("flush_before", 32'(e.flush_before), 32'(vertex.flush_before));
        report_field("flushed_indices", 32'(e.flushed_indices), 32'(vertex.flushed_indices));
        report_field("corner", 32'(e.corner), 32'(vertex.corner));
        report_field("last", 32'(e.last), 32'(vertex.last));
      end
    end
  end

  initial begin
    do @(posedge clk); while (rst);
    forever begin
      vertex_ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 30)) @(posedge clk);
      if (!quiet) begin
        vertex_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  initial begin
    row_t        directed[$];
    logic [31:0] id_pool[ID_POOL];
    logic [31:0] id;
    int          pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed.insert(directed.size(), '{make_sprite(0, 0, 0, 0, 0, 0, 32'hA5C3_0F81, 0,
                        32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321), 1'b1,
                        first_corner(0, 0, 0, 0, 0, 32'hA5C3_0F81)});
    directed.insert(directed.size(), '{make_sprite(0, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                        first_corner(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'hFFFF_FFFF, 0, 32'hFFFF_FFFF)});
    directed.insert(directed.size(), '{make_sprite(0, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0000_FFFF,
                        32'hFFFF_0000, 32'h5555_AAAA, 32'hAAAA_5555), 1'b1,
                        first_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h0000_FFFF, 0, 0)});
    directed.insert(directed.size(), '{make_sprite(0, 32'h0001_8000, 32'hFFFF_0000,
                        32'h0000_4000, 32'hFFFE_0000, 32'h0003_0000, 32'h8040_2010,
                        1, 2, 3, 4), 1'b0, '0});
    directed.insert(directed.size(), '{make_sprite(1, 32'h0010_0000, 32'h0020_0000,
                        32'h0000_0001, 32'h0008_0000, 32'h0008_0000, 32'hDEAD_BEEF,
                        32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000), 1'b1,
                        first_corner(32'h0010_0000, 32'h0020_0000, 32'h0000_0001,
                                     0, 1, 0)});
    directed.insert(directed.size(), '{make_sprite(32'hFFFF_FFFF, 0, 0, 0, 32'h0001_0000,
                        32'h0001_0000, 32'h1111_1111, 32'h0101_0101, 2, 3, 4), 1'b1,
                        first_corner(0, 0, 0, 32'h0101_0101, 2, 0)});
    directed.insert(directed.size(), '{make_sprite(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 1, 1, 32'h2222_2222, 32'h7777_7777, 5, 6, 7), 1'b1,
                        first_corner(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'h7777_7777, 1, 0)});
    directed.insert(directed.size(), '{make_sprite(32'h8000_0000, 5, 6, 7, 8, 9,
                        32'h3333_3333, 32'h0F0F_0F0F, 8, 9, 10), 1'b1,
                        first_corner(5, 6, 7, 32'h0F0F_0F0F, 3, 0)});
    directed.insert(directed.size(), '{make_sprite(32'hFFFF_FFFF, 10, 11, 12, 13, 14,
                        32'h4444_4444, 32'hF0F0_F0F0, 15, 16, 17), 1'b1,
                        first_corner(10, 11, 12, 32'hF0F0_F0F0, 2, 0)});
    directed.insert(directed.size(), '{rand_sprite(0), 1'b0, '0});
    directed.insert(directed.size(), '{rand_sprite(2), 1'b0, '0});
    directed.insert(directed.size(), '{rand_sprite(32'h8000_0000), 1'b0, '0});

    foreach (directed[i]) begin
      maybe_pause();
      send_sprite(directed[i].s);
      if (directed[i].typed) pending_verts[pending_verts.size() - 4] = directed[i].v0;
    end

    // Hold off new requests until the pipeline has drained completely.
    sprite_valid <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk);

    // Fill the slot table, then miss on a full table.
    id = 32'h0000_1000;
    while (tex_used < SLOT_COUNT) begin
      maybe_pause();
      send_sprite(rand_sprite(id));
      id++;
    end
    maybe_pause();
    send_sprite(rand_sprite(32'hDEAD_0001));

    foreach (id_pool[i]) begin
      do id_pool[i] = $urandom; while (id_pool[i] == 0);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 25) id = 0;
      else if (pick < 92) id = id_pool[$urandom_range(0, ID_POOL - 1)];
      else id = $urandom;
      maybe_pause();
      send_sprite(rand_sprite(id));
    end
    sprite_valid <= 1'b0;

    while (pending_verts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
